// File: sv/rmpi_pkg.sv
// shared types and constants for the recursive mutex with priority inheritance
// used by the wait memory, the controller and the top level
`default_nettype none

package rmpi_pkg;

    localparam int WAIT_SLOTS = 16;
    localparam int SLOT_W     = $clog2(WAIT_SLOTS);
    localparam int CNT_W      = $clog2(WAIT_SLOTS + 1);
    localparam int TASK_W     = 8;
    localparam int PRIO_W     = 8;
    localparam int DEPTH_W    = 8;
    localparam logic [DEPTH_W-1:0] MAX_NEST_DEPTH = 8'd255;

    typedef enum logic [0:0] {
        OP_LOCK   = 1'b0,
        OP_UNLOCK = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_BLOCKED   = 3'd1,
        ST_RELEASED  = 3'd2,
        ST_LOWERED   = 3'd3,
        ST_NOT_OWNER = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_FINISH
    } ctrl_state_t;

    typedef struct packed {
        op_t               op;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] task_prio;
    } req_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] prio;
    } slot_t;

    typedef struct packed {
        status_t            status;
        logic               prio_change_valid;
        logic [TASK_W-1:0]  prio_change_task;
        logic [PRIO_W-1:0]  prio_change_value;
        logic               wake_valid;
        logic [TASK_W-1:0]  wake_task;
        logic [DEPTH_W-1:0] depth_now;
    } result_t;

endpackage

`default_nettype wire

// File: sv/rmpi_wait_mem.sv
// wait table storage: task number and priority per slot
// one write port, one read port with registered data; depends on rmpi_pkg
`default_nettype none

module rmpi_wait_mem
    import rmpi_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [SLOT_W-1:0] wr_addr,
    input  wire slot_t             wr_data,
    input  wire logic              rd_en,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output slot_t                  rd_data
);

    slot_t mem [WAIT_SLOTS];
    slot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/rmpi_ctrl.sv
// request sequencer: owner state, slot valid bits, wait table scan and update
// drives rmpi_wait_mem; depends on rmpi_pkg
`default_nettype none

module rmpi_ctrl
    import rmpi_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire req_t              req,
    input  wire logic              out_free,
    output logic                   res_valid,
    output result_t                res,
    output logic                   mem_wr_en,
    output logic [SLOT_W-1:0]      mem_wr_addr,
    output slot_t                  mem_wr_data,
    output logic                   mem_rd_en,
    output logic [SLOT_W-1:0]      mem_rd_addr,
    input  wire slot_t             mem_rd_data
);

    ctrl_state_t         state_reg, state_next;
    req_t                req_reg, req_next;
    logic                owner_valid_reg, owner_valid_next;
    logic [TASK_W-1:0]   owner_task_reg, owner_task_next;
    logic [PRIO_W-1:0]   owner_prio_reg, owner_prio_next;
    logic [PRIO_W-1:0]   root_prio_reg, root_prio_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [WAIT_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]    issue_cnt_reg, issue_cnt_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                hit_reg, hit_next;
    logic [SLOT_W-1:0]   hit_idx_reg, hit_idx_next;
    logic                best_reg, best_next;
    logic [SLOT_W-1:0]   best_idx_reg, best_idx_next;
    logic [PRIO_W-1:0]   best_prio_reg, best_prio_next;
    logic [TASK_W-1:0]   best_task_reg, best_task_next;

    logic                is_owner;
    logic                scan_need;
    logic                issue_more;
    logic                slot_live;
    logic                free_found;
    logic [SLOT_W-1:0]   free_idx;
    logic                have_slot;
    logic [SLOT_W-1:0]   use_idx;
    logic                commit;

    // lowest free slot straight from the valid flops
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = WAIT_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign is_owner   = owner_valid_reg && (owner_task_reg == req.task_id);
    // owner relock and non-final unlock need no pass over the table
    assign scan_need  = (req.op == OP_LOCK) ? !is_owner
                      : (is_owner && depth_reg == DEPTH_W'(1));
    assign issue_more = issue_cnt_reg < CNT_W'(WAIT_SLOTS);
    assign slot_live  = rd_pend_reg && valid_reg[rd_idx_reg];
    assign have_slot  = hit_reg || free_found;
    assign use_idx    = hit_reg ? hit_idx_reg : free_idx;
    assign commit     = (state_reg == CS_FINISH) && out_free;

    assign req_ready   = (state_reg == CS_IDLE);
    assign mem_rd_en   = (state_reg == CS_SCAN) && issue_more;
    assign mem_rd_addr = issue_cnt_reg[SLOT_W-1:0];

    always_comb begin
        state_next       = state_reg;
        req_next         = req_reg;
        owner_valid_next = owner_valid_reg;
        owner_task_next  = owner_task_reg;
        owner_prio_next  = owner_prio_reg;
        root_prio_next   = root_prio_reg;
        depth_next       = depth_reg;
        valid_next       = valid_reg;
        issue_cnt_next   = issue_cnt_reg;
        rd_pend_next     = 1'b0;
        rd_idx_next      = issue_cnt_reg[SLOT_W-1:0];
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        best_next        = best_reg;
        best_idx_next    = best_idx_reg;
        best_prio_next   = best_prio_reg;
        best_task_next   = best_task_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = use_idx;
        mem_wr_data      = '{task_id: req_reg.task_id, prio: req_reg.task_prio};
        res_valid        = 1'b0;
        res              = '0;

        unique case (state_reg)
            CS_IDLE: begin
                if (req_valid) begin
                    req_next       = req;
                    issue_cnt_next = '0;
                    hit_next       = 1'b0;
                    best_next      = 1'b0;
                    state_next     = scan_need ? CS_SCAN : CS_FINISH;
                end
            end
            CS_SCAN: begin
                rd_pend_next = issue_more;
                if (issue_more) begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (slot_live && !hit_reg && mem_rd_data.task_id == req_reg.task_id) begin
                    hit_next     = 1'b1;
                    hit_idx_next = rd_idx_reg;
                end
                if (slot_live && (!best_reg || mem_rd_data.prio > best_prio_reg)) begin
                    best_next      = 1'b1;
                    best_idx_next  = rd_idx_reg;
                    best_prio_next = mem_rd_data.prio;
                    best_task_next = mem_rd_data.task_id;
                end
                if (!issue_more && !rd_pend_reg) begin
                    state_next = CS_FINISH;
                end
            end
            CS_FINISH: begin
                if (commit) begin
                    res_valid  = 1'b1;
                    state_next = CS_IDLE;
                    if (req_reg.op == OP_LOCK) begin
                        if (!owner_valid_reg) begin
                            if (hit_reg) begin
                                valid_next[hit_idx_reg] = 1'b0;
                            end
                            owner_valid_next = 1'b1;
                            owner_task_next  = req_reg.task_id;
                            owner_prio_next  = req_reg.task_prio;
                            root_prio_next   = req_reg.task_prio;
                            depth_next       = DEPTH_W'(1);
                            res.status       = ST_GRANTED;
                        end else if (owner_task_reg == req_reg.task_id) begin
                            if (depth_reg >= MAX_NEST_DEPTH) begin
                                res.status = ST_FULL;
                            end else begin
                                depth_next = depth_reg + DEPTH_W'(1);
                                res.status = ST_GRANTED;
                            end
                        end else if (!have_slot) begin
                            res.status = ST_FULL;
                        end else begin
                            mem_wr_en           = 1'b1;
                            valid_next[use_idx] = 1'b1;
                            if (req_reg.task_prio > owner_prio_reg) begin
                                owner_prio_next       = req_reg.task_prio;
                                res.prio_change_valid = 1'b1;
                                res.prio_change_task  = owner_task_reg;
                                res.prio_change_value = req_reg.task_prio;
                            end
                            res.status = ST_BLOCKED;
                        end
                    end else begin
                        if (!owner_valid_reg || owner_task_reg != req_reg.task_id
                                || depth_reg == '0) begin
                            res.status = ST_NOT_OWNER;
                        end else if (depth_reg != DEPTH_W'(1)) begin
                            depth_next = depth_reg - DEPTH_W'(1);
                            res.status = ST_LOWERED;
                        end else begin
                            depth_next = '0;
                            if (owner_prio_reg > root_prio_reg) begin
                                res.prio_change_valid = 1'b1;
                                res.prio_change_task  = owner_task_reg;
                                res.prio_change_value = root_prio_reg;
                            end
                            owner_prio_next  = root_prio_reg;
                            owner_valid_next = 1'b0;
                            if (best_reg) begin
                                valid_next[best_idx_reg] = 1'b0;
                                res.wake_valid = 1'b1;
                                res.wake_task  = best_task_reg;
                            end
                            res.status = ST_RELEASED;
                        end
                    end
                    res.depth_now = depth_next;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= CS_IDLE;
            owner_valid_reg <= 1'b0;
            owner_task_reg  <= '0;
            owner_prio_reg  <= '0;
            root_prio_reg   <= '0;
            depth_reg       <= '0;
            valid_reg       <= '0;
            rd_pend_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            owner_valid_reg <= owner_valid_next;
            owner_task_reg  <= owner_task_next;
            owner_prio_reg  <= owner_prio_next;
            root_prio_reg   <= root_prio_next;
            depth_reg       <= depth_next;
            valid_reg       <= valid_next;
            rd_pend_reg     <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        issue_cnt_reg <= issue_cnt_next;
        rd_idx_reg    <= rd_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_task_reg <= best_task_next;
    end

endmodule

`default_nettype wire

// File: sv/recursive_mutex_priority_inherit.sv
// top level of the recursive mutex with priority inheritance
// instantiates rmpi_ctrl and rmpi_wait_mem and holds the result register; depends on rmpi_pkg
`default_nettype none

// Hardware recursive mutex with priority inheritance. Each request is a lock or
// an unlock from one task together with its current priority; each request gives
// exactly one result. A lock by the owner and an unlock that leaves the mutex held
// skip the wait table. A lock by another task, a lock of a free mutex and the
// unlock that frees the mutex walk the wait table memory one slot per cycle to
// find the task's slot or the best waiter. A new request is taken the cycle after
// the previous result is handed to the result register, even while that result
// still waits for m_tready.

module recursive_mutex_priority_inherit
    import rmpi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // task_id[7:0], task_prio[15:8]
    input  wire logic [0:0]  s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // status[2:0], prio_change_valid[3],
                                        // prio_change_task[11:4], prio_change_value[19:12],
                                        // wake_valid[20], wake_task[28:21], depth_now[36:29]
);

    req_t              req;
    logic              res_valid;
    result_t           res;
    logic              out_free;
    logic              m_valid_reg;
    result_t           m_data_reg;
    logic              mem_wr_en;
    logic [SLOT_W-1:0] mem_wr_addr;
    slot_t             mem_wr_data;
    logic              mem_rd_en;
    logic [SLOT_W-1:0] mem_rd_addr;
    slot_t             mem_rd_data;

    assign req = '{op: op_t'(s_tuser[0]), task_id: s_tdata[7:0], task_prio: s_tdata[15:8]};

    assign out_free = !m_valid_reg || m_tready;

    rmpi_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req         (req),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    rmpi_wait_mem u_wait_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_data_reg.depth_now, m_data_reg.wake_task,
                       m_data_reg.wake_valid, m_data_reg.prio_change_value,
                       m_data_reg.prio_change_task, m_data_reg.prio_change_valid,
                       m_data_reg.status};

endmodule

`default_nettype wire

// File: sv/rmpi_checker.sv
// port-level checks for recursive_mutex_priority_inherit
// bound to the top level below; depends on rmpi_pkg for the status codes
`default_nettype none

module rmpi_checker
    import rmpi_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // priority changes only come with a block or a release
    a_prio_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> (m_tdata[2:0] == ST_BLOCKED || m_tdata[2:0] == ST_RELEASED))
        else $error("priority change on wrong status");

    // a wake only on a release that leaves the mutex free
    a_wake_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20] |-> m_tdata[2:0] == ST_RELEASED && m_tdata[36:29] == 8'd0)
        else $error("wake without release");

    // a grant always leaves the mutex held
    a_grant_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == ST_GRANTED |-> m_tdata[36:29] != 8'd0)
        else $error("grant with zero depth");

    // side fields read zero when their flag is low
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3] || m_tdata[19:4] == 16'd0)
                  && (m_tdata[20] || m_tdata[28:21] == 8'd0))
        else $error("stale side fields");

endmodule

bind recursive_mutex_priority_inherit rmpi_checker u_rmpi_checker (.*);

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
// testbench for recursive_mutex_priority_inherit: directed and state-aware random
// lock/unlock traffic checked against an in-bench model of the mutex and its wait slots
// depends on rmpi_pkg and the block's rtl

module tb;
    import rmpi_pkg::*;

    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RUN_LIMIT_NS   = 6_000_000;
    localparam int POOL_SIZE      = 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // task_id[7:0], task_prio[15:8]
    logic [0:0]  s_tuser  = '0;   // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // status[2:0], prio_change_valid[3], prio_change_task[11:4],
                                  // prio_change_value[19:12], wake_valid[20], wake_task[28:21],
                                  // depth_now[36:29]

    // mutex model state
    logic              mtx_held      = 1'b0;
    logic [TASK_W-1:0] mtx_owner     = '0;
    logic [PRIO_W-1:0] mtx_cur_prio  = '0;
    logic [PRIO_W-1:0] mtx_root_prio = '0;
    logic [DEPTH_W-1:0] mtx_depth    = '0;
    logic              slot_busy [WAIT_SLOTS] = '{default: 1'b0};
    logic [TASK_W-1:0] slot_task [WAIT_SLOTS];
    logic [PRIO_W-1:0] slot_prio [WAIT_SLOTS];

    result_t           results_due[$];
    logic [TASK_W-1:0] woken_tasks[$];
    logic [TASK_W-1:0] task_pool[POOL_SIZE];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int rx_hold_trig  = 0;
    int rx_hold_seen  = 0;
    int rx_hold_left  = 0;

    recursive_mutex_priority_inherit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic result_t mutex_predict(op_t op, logic [TASK_W-1:0] tid,
                                              logic [PRIO_W-1:0] prio);
        result_t res;
        int hit;
        int best;
        res  = '0;
        hit  = -1;
        best = -1;
        for (int i = 0; i < WAIT_SLOTS; i++) begin
            if (hit < 0 && slot_busy[i] && slot_task[i] == tid) hit = i;
        end
        if (op == OP_LOCK) begin
            if (!mtx_held) begin
                // a waiter that grabs the free mutex gives up its slot
                if (hit >= 0) slot_busy[hit] = 1'b0;
                mtx_held      = 1'b1;
                mtx_owner     = tid;
                mtx_cur_prio  = prio;
                mtx_root_prio = prio;
                mtx_depth     = 8'd1;
                res.status    = ST_GRANTED;
            end else if (mtx_owner == tid) begin
                if (mtx_depth >= MAX_NEST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    mtx_depth  = mtx_depth + 8'd1;
                    res.status = ST_GRANTED;
                end
            end else begin
                // parked task keeps its slot, a new one takes the lowest free slot
                for (int i = 0; i < WAIT_SLOTS; i++) begin
                    if (hit < 0 && !slot_busy[i]) hit = i;
                end
                if (hit < 0) begin
                    res.status = ST_FULL;
                end else begin
                    slot_busy[hit] = 1'b1;
                    slot_task[hit] = tid;
                    slot_prio[hit] = prio;
                    if (prio > mtx_cur_prio) begin
                        mtx_cur_prio          = prio;
                        res.prio_change_valid = 1'b1;
                        res.prio_change_task  = mtx_owner;
                        res.prio_change_value = prio;
                    end
                    res.status = ST_BLOCKED;
                end
            end
        end else if (!mtx_held || mtx_owner != tid || mtx_depth == 0) begin
            res.status = ST_NOT_OWNER;
        end else begin
            mtx_depth = mtx_depth - 8'd1;
            if (mtx_depth != 0) begin
                res.status = ST_LOWERED;
            end else begin
                if (mtx_cur_prio > mtx_root_prio) begin
                    res.prio_change_valid = 1'b1;
                    res.prio_change_task  = mtx_owner;
                    res.prio_change_value = mtx_root_prio;
                end
                mtx_cur_prio = mtx_root_prio;
                mtx_held     = 1'b0;
                // strict greater keeps ties on the lowest slot
                for (int i = 0; i < WAIT_SLOTS; i++) begin
                    if (slot_busy[i] && (best < 0 || slot_prio[i] > slot_prio[best])) best = i;
                end
                if (best >= 0) begin
                    slot_busy[best] = 1'b0;
                    res.wake_valid  = 1'b1;
                    res.wake_task   = slot_task[best];
                    woken_tasks.push_back(slot_task[best]);
                end
                res.status = ST_RELEASED;
            end
        end
        res.depth_now = mtx_depth;
        return res;
    endfunction

    task automatic issue_request(op_t op, logic [TASK_W-1:0] tid, logic [PRIO_W-1:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {prio, tid};
        do @(posedge aclk); while (!s_tready);
        results_due.push_back(mutex_predict(op, tid, prio));
    endtask

    task automatic await_results_clear();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);
    endtask

    task automatic release_mutex_fully();
        while (mtx_held) issue_request(OP_UNLOCK, mtx_owner, 8'($urandom));
    endtask

    task automatic run_random_traffic(int count, int span);
        int pick;
        logic [TASK_W-1:0] tid;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            tid  = task_pool[$urandom_range(span - 1)];
            if (mtx_held && pick < 30)
                issue_request(OP_UNLOCK, mtx_owner, 8'($urandom));
            else if (mtx_held && pick < 42)
                issue_request(OP_LOCK, mtx_owner, 8'($urandom));
            else if (woken_tasks.size() != 0 && pick < 52)
                issue_request(OP_LOCK, woken_tasks.pop_front(), 8'($urandom));
            else if (pick < 80)
                issue_request(OP_LOCK, tid, 8'($urandom));
            else if (pick < 88)
                issue_request(OP_UNLOCK, tid, 8'($urandom));
            else
                issue_request(op_t'($urandom_range(1)), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_directed_cases();
        issue_request(OP_UNLOCK, 8'h00, 8'h00);   // unlock of a free mutex
        issue_request(OP_LOCK,   8'hFF, 8'h00);
        issue_request(OP_LOCK,   8'hFF, 8'hFF);   // relock, input priority ignored
        issue_request(OP_LOCK,   8'h00, 8'hFF);   // boost owner to top priority
        issue_request(OP_LOCK,   8'h00, 8'h80);   // already waiting, slot refreshed
        issue_request(OP_LOCK,   8'h55, 8'hFF);   // equal priority, no boost
        issue_request(OP_UNLOCK, 8'h00, 8'h00);   // not the owner
        issue_request(OP_UNLOCK, 8'hFF, 8'h00);   // depth lowered, still held
        issue_request(OP_UNLOCK, 8'hFF, 8'h00);   // restore and wake best waiter
        issue_request(OP_LOCK,   8'h00, 8'h10);   // waiter takes free mutex, slot cleared
        issue_request(OP_LOCK,   8'hAA, 8'h01);
        issue_request(OP_UNLOCK, 8'h00, 8'h00);   // release without priority change
        issue_request(OP_LOCK,   8'h33, 8'h20);
        issue_request(OP_UNLOCK, 8'h33, 8'h20);   // nobody waiting
        issue_request(OP_LOCK,   8'h01, 8'h05);
        issue_request(OP_LOCK,   8'h02, 8'h09);
        issue_request(OP_LOCK,   8'h03, 8'h09);
        issue_request(OP_UNLOCK, 8'h01, 8'h05);   // tie goes to the lower slot
        issue_request(OP_LOCK,   8'h03, 8'h09);
        issue_request(OP_UNLOCK, 8'h03, 8'h09);
        issue_request(OP_LOCK,   8'h02, 8'h09);
        issue_request(OP_UNLOCK, 8'h02, 8'h09);
        await_results_clear();
    endtask

    task automatic test_wait_table_full();
        release_mutex_fully();
        issue_request(OP_LOCK, 8'hF0, 8'h00);
        for (int i = 0; i <= WAIT_SLOTS; i++) issue_request(OP_LOCK, 8'(8'hC0 + i), 8'(i * 15 + 1));
        // parked task refreshed while the table is full, then a newcomer refused
        issue_request(OP_LOCK, 8'hC0, 8'hFF);
        issue_request(OP_LOCK, 8'hEE, 8'hFE);
        release_mutex_fully();
        await_results_clear();
    endtask

    task automatic test_depth_overflow();
        release_mutex_fully();
        repeat (int'(MAX_NEST_DEPTH) + 1) issue_request(OP_LOCK, 8'h7E, 8'h81);
        release_mutex_fully();
        await_results_clear();
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        rx_hold_trig++;
        run_random_traffic(40, 16);
        await_results_clear();
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct, int count, int span);
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        run_random_traffic(count, span);
        await_results_clear();
    endtask

    // result receiver, with an occasional long hold-off
    always @(posedge aclk) begin
        if (rx_hold_trig != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_trig;
            rx_hold_left <= RX_HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $error("result 0x%h with no request outstanding", m_tdata);
                fail_count++;
            end else begin
                want = results_due.pop_front();
                check_field("status", 8'(want.status), 8'(m_tdata[2:0]));
                check_field("prio_change_valid", 8'(want.prio_change_valid), 8'(m_tdata[3]));
                check_field("prio_change_task", want.prio_change_task, m_tdata[11:4]);
                check_field("prio_change_value", want.prio_change_value, m_tdata[19:12]);
                check_field("wake_valid", 8'(want.wake_valid), 8'(m_tdata[20]));
                check_field("wake_task", want.wake_task, m_tdata[28:21]);
                check_field("depth_now", want.depth_now, m_tdata[36:29]);
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) task_pool[i] = 8'($urandom);
        send_idle_pct = 17;
        recv_idle_pct = 85;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_wait_table_full();
        test_depth_overflow();
        test_output_stall();
        test_random_traffic(17, 85, 370, 12);
        test_random_traffic(85, 17, 370, POOL_SIZE);
        test_random_traffic(0, 0, 370, 24);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: recursive_mutex_priority_inherit.f
sv/rmpi_pkg.sv
sv/rmpi_wait_mem.sv
sv/rmpi_ctrl.sv
sv/recursive_mutex_priority_inherit.sv
sv/rmpi_checker.sv
test/tb.sv
